@@ hw/rtl/rbsi_pkg.sv @@
package rbsi_pkg;

	localparam int COORD_WIDTH   = 32;
	localparam int DEF_FRAC_BITS = 16;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;

	localparam coord_t T_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
	localparam coord_t T_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

	typedef struct packed {
		coord_t box_min_x;
		coord_t box_min_y;
		coord_t box_min_z;
		coord_t box_max_x;
		coord_t box_max_y;
		coord_t box_max_z;
		coord_t origin_x;
		coord_t origin_y;
		coord_t origin_z;
		coord_t dir_x;
		coord_t dir_y;
		coord_t dir_z;
	} rbsi_req_t;

	typedef struct packed {
		logic   hit;
		coord_t t_enter;
		coord_t t_exit;
	} rbsi_rsp_t;

	// per-axis interval as one lane hands it to the merge stage
	typedef struct packed {
		logic   miss;
		coord_t t_near;
		coord_t t_far;
	} rbsi_slab_t;

endpackage

@@ hw/rtl/ray_box_slab_intersect_unit.sv @@
// Ray versus axis-aligned box test, signed fixed point (Q16.16 by default).
// Request channel: req_valid / req_ready carry one ray and one box in req.
// Response channel: rsp_valid / rsp_ready carry hit, t_enter and t_exit;
// both distances read zero on a miss.
// Three axis lanes run in parallel, each with two pipelined restoring
// dividers, one quotient bit per stage; a merge stage keeps the largest
// near and smallest far distance.
// The latency from request accept to rsp_valid grows with the divider depth.
// Throughput: one request per cycle while responses are taken.
// A two-entry response buffer sits at the output. When it fills, the whole
// pipeline holds and req_ready drops; req_ready depends only on buffer
// occupancy, never on rsp_ready in the same cycle.
// Reset clears the pipeline valid bits and the buffer occupancy and
// pointers, not the buffer data; req_ready is high right after reset.
module ray_box_slab_intersect_unit
	import rbsi_pkg::*;
#(
	parameter int FRAC_BITS = DEF_FRAC_BITS
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  rbsi_req_t req,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output rbsi_rsp_t rsp
);

	localparam int LAT = COORD_WIDTH + FRAC_BITS + 6;

	logic       en;
	logic       push;
	logic       pop;
	logic [LAT-1:0] vld_q;
	logic [1:0] cnt_q;
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	rbsi_rsp_t  buf_q [2];

	rbsi_slab_t slab_x;
	rbsi_slab_t slab_y;
	rbsi_slab_t slab_z;
	rbsi_rsp_t  res;

	assign en        = !cnt_q[1];
	assign req_ready = en;
	assign push      = en && vld_q[LAT-1];
	assign rsp_valid = (cnt_q != 2'd0);
	assign pop       = rsp_valid && rsp_ready;
	assign rsp       = buf_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], req_valid};
		end
	end

	rbsi_axis_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_x (
		.clk  (clk),
		.en   (en),
		.lo   (req.box_min_x),
		.hi   (req.box_max_x),
		.org  (req.origin_x),
		.dir  (req.dir_x),
		.slab (slab_x)
	);

	rbsi_axis_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_y (
		.clk  (clk),
		.en   (en),
		.lo   (req.box_min_y),
		.hi   (req.box_max_y),
		.org  (req.origin_y),
		.dir  (req.dir_y),
		.slab (slab_y)
	);

	rbsi_axis_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_z (
		.clk  (clk),
		.en   (en),
		.lo   (req.box_min_z),
		.hi   (req.box_max_z),
		.org  (req.origin_z),
		.dir  (req.dir_z),
		.slab (slab_z)
	);

	rbsi_merge u_merge (
		.clk    (clk),
		.en     (en),
		.slab_x (slab_x),
		.slab_y (slab_y),
		.slab_z (slab_z),
		.rsp    (res)
	);

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

@@ hw/rtl/rbsi_slab_div.sv @@
module rbsi_slab_div
	import rbsi_pkg::*;
#(
	parameter int FRAC_BITS = DEF_FRAC_BITS
) (
	input  logic                       clk,
	input  logic                       en,
	input  logic signed [COORD_WIDTH:0] diff,
	input  coord_t                     dir,
	output coord_t                     t
);

	localparam int CW    = COORD_WIDTH;
	localparam int NSTEP = COORD_WIDTH + FRAC_BITS;

	logic [CW:0]   diff_mag;
	logic [CW-1:0] dir_mag;

	logic [CW-1:0] num_s [NSTEP];
	logic [CW-1:0] rem_s [NSTEP];
	logic [CW-1:0] den_s [NSTEP];
	logic [CW-1:0] quo_s [NSTEP+1];
	logic          ovf_s [NSTEP+1];
	logic          neg_s [NSTEP+1];

	always_comb begin
		diff_mag = diff[CW] ? -diff : diff;
		dir_mag  = dir[CW-1] ? -dir : dir;
	end

	// |diff| < 2^CW, so the top bit of the magnitude is always clear
	always_ff @(posedge clk) begin
		if (en) begin
			num_s[0] <= diff_mag[CW-1:0];
			rem_s[0] <= '0;
			den_s[0] <= dir_mag;
			quo_s[0] <= '0;
			ovf_s[0] <= 1'b0;
			neg_s[0] <= diff[CW] ^ dir[CW-1];
		end
	end

	// One restoring step per stage over numerator * 2^FRAC_BITS; quotient bits
	// that leave the kept window fold into the overflow flag.
	for (genvar k = 0; k < NSTEP; k++) begin : g_step
		logic [CW:0] rs;
		logic [CW:0] rd;
		logic        ge;

		always_comb begin
			rs = {rem_s[k], num_s[k][CW-1]};
			rd = rs - {1'b0, den_s[k]};
			ge = (rs >= {1'b0, den_s[k]});
		end

		always_ff @(posedge clk) begin
			if (en) begin
				quo_s[k+1] <= {quo_s[k][CW-2:0], ge};
				ovf_s[k+1] <= ovf_s[k] | quo_s[k][CW-1];
				neg_s[k+1] <= neg_s[k];
			end
		end

		if (k < NSTEP - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					num_s[k+1] <= {num_s[k][CW-2:0], 1'b0};
					rem_s[k+1] <= ge ? rd[CW-1:0] : rs[CW-1:0];
					den_s[k+1] <= den_s[k];
				end
			end
		end
	end

	logic          sat;
	logic [CW-1:0] qmag;

	always_comb begin
		sat  = ovf_s[NSTEP] | quo_s[NSTEP][CW-1];
		qmag = {1'b0, quo_s[NSTEP][CW-2:0]};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (neg_s[NSTEP]) begin
				t <= sat ? T_MIN : coord_t'(-qmag);
			end else begin
				t <= sat ? T_MAX : coord_t'(qmag);
			end
		end
	end

endmodule

@@ hw/rtl/rbsi_axis_lane.sv @@
module rbsi_axis_lane
	import rbsi_pkg::*;
#(
	parameter int FRAC_BITS = DEF_FRAC_BITS
) (
	input  logic       clk,
	input  logic       en,
	input  coord_t     lo,
	input  coord_t     hi,
	input  coord_t     org,
	input  coord_t     dir,
	output rbsi_slab_t slab
);

	localparam int CW      = COORD_WIDTH;
	localparam int DIV_LAT = COORD_WIDTH + FRAC_BITS + 2;

	logic signed [CW:0] diff_lo_s1;
	logic signed [CW:0] diff_hi_s1;
	coord_t             dir_s1;
	logic               zero_s[DIV_LAT+1];
	logic               zmiss_s[DIV_LAT+1];

	coord_t t_lo;
	coord_t t_hi;

	always_ff @(posedge clk) begin
		if (en) begin
			diff_lo_s1 <= {lo[CW-1], lo} - {org[CW-1], org};
			diff_hi_s1 <= {hi[CW-1], hi} - {org[CW-1], org};
			dir_s1     <= dir;
			zero_s[0]  <= (dir == '0);
			zmiss_s[0] <= (org < lo) || (org > hi);
		end
	end

	// hold the zero-direction flags in step with the dividers
	for (genvar k = 0; k < DIV_LAT; k++) begin : g_side
		always_ff @(posedge clk) begin
			if (en) begin
				zero_s[k+1]  <= zero_s[k];
				zmiss_s[k+1] <= zmiss_s[k];
			end
		end
	end

	rbsi_slab_div #(.FRAC_BITS(FRAC_BITS)) u_div_lo (
		.clk  (clk),
		.en   (en),
		.diff (diff_lo_s1),
		.dir  (dir_s1),
		.t    (t_lo)
	);

	rbsi_slab_div #(.FRAC_BITS(FRAC_BITS)) u_div_hi (
		.clk  (clk),
		.en   (en),
		.diff (diff_hi_s1),
		.dir  (dir_s1),
		.t    (t_hi)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			if (zero_s[DIV_LAT]) begin
				// parallel axis: no bound, only the containment test
				slab.miss   <= zmiss_s[DIV_LAT];
				slab.t_near <= T_MIN;
				slab.t_far  <= T_MAX;
			end else if (t_lo > t_hi) begin
				slab.miss   <= 1'b0;
				slab.t_near <= t_hi;
				slab.t_far  <= t_lo;
			end else begin
				slab.miss   <= 1'b0;
				slab.t_near <= t_lo;
				slab.t_far  <= t_hi;
			end
		end
	end

endmodule

@@ hw/rtl/rbsi_merge.sv @@
module rbsi_merge
	import rbsi_pkg::*;
(
	input  logic       clk,
	input  logic       en,
	input  rbsi_slab_t slab_x,
	input  rbsi_slab_t slab_y,
	input  rbsi_slab_t slab_z,
	output rbsi_rsp_t  rsp
);

	coord_t near_xy;
	coord_t far_xy;
	coord_t t0_s1;
	coord_t t1_s1;
	logic   miss_s1;

	always_comb begin
		near_xy = (slab_x.t_near > slab_y.t_near) ? slab_x.t_near : slab_y.t_near;
		far_xy  = (slab_x.t_far < slab_y.t_far) ? slab_x.t_far : slab_y.t_far;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t0_s1   <= (near_xy > slab_z.t_near) ? near_xy : slab_z.t_near;
			t1_s1   <= (far_xy < slab_z.t_far) ? far_xy : slab_z.t_far;
			miss_s1 <= slab_x.miss | slab_y.miss | slab_z.miss;
		end
	end

	logic hit;

	assign hit = !miss_s1 && !(t0_s1 > t1_s1);

	// zero both distances on a miss
	always_ff @(posedge clk) begin
		if (en) begin
			rsp.hit     <= hit;
			rsp.t_enter <= hit ? t0_s1 : '0;
			rsp.t_exit  <= hit ? t1_s1 : '0;
		end
	end

endmodule

@@ tb/ray_box_slab_intersect_unit_test.sv @@
`timescale 1ns / 100ps

module ray_box_slab_intersect_unit_test;
	import rbsi_pkg::*;

	localparam int     RANDOM_RAYS = 1250;
	localparam coord_t Q_ONE       = coord_t'(64'd1 << DEF_FRAC_BITS);

	typedef enum {RAY_AIMED, RAY_RAW, RAY_EDGE, RAY_SHORT} ray_kind_e;
	typedef enum {RX_ALWAYS, RX_HALF, RX_MOSTLY, RX_RARELY} rx_pace_e;

	class ray_hit_scoreboard;
		rbsi_rsp_t expected_hits[$];
		int        errors;
		int        responses;

		// (diff << FRAC) / step, truncated toward zero, clamped to the coord range
		function longint slab_distance(longint diff, longint step);
			longint unsigned num;
			longint unsigned den;
			longint unsigned quo;
			longint unsigned cap;
			cap = 64'd1 << (COORD_WIDTH - 1);
			num = (diff < 0) ? -diff : diff;
			den = (step < 0) ? -step : step;
			quo = (num << DEF_FRAC_BITS) / den;
			if ((diff < 0) != (step < 0))
				return (quo >= cap) ? longint'(T_MIN) : -longint'(quo);
			return (quo >= cap) ? longint'(T_MAX) : longint'(quo);
		endfunction

		function rbsi_rsp_t intersect_ray_box(rbsi_req_t r);
			coord_t    lo [3];
			coord_t    hi [3];
			coord_t    org [3];
			coord_t    dir [3];
			longint    t0;
			longint    t1;
			longint    tn;
			longint    tf;
			longint    sw;
			bit        miss;
			rbsi_rsp_t res;
			lo  = '{r.box_min_x, r.box_min_y, r.box_min_z};
			hi  = '{r.box_max_x, r.box_max_y, r.box_max_z};
			org = '{r.origin_x, r.origin_y, r.origin_z};
			dir = '{r.dir_x, r.dir_y, r.dir_z};
			t0 = longint'(T_MIN);
			t1 = longint'(T_MAX);
			miss = 1'b0;
			for (int a = 0; a < 3; a++) begin
				if (dir[a] == 0) begin
					// parallel to the slab: unbounded if inside, else no hit at all
					if (org[a] < lo[a] || org[a] > hi[a])
						miss = 1'b1;
				end else begin
					tn = slab_distance(longint'(lo[a]) - longint'(org[a]), longint'(dir[a]));
					tf = slab_distance(longint'(hi[a]) - longint'(org[a]), longint'(dir[a]));
					if (tn > tf) begin
						sw = tn;
						tn = tf;
						tf = sw;
					end
					if (tn > t0)
						t0 = tn;
					if (tf < t1)
						t1 = tf;
				end
			end
			if (t0 > t1)
				miss = 1'b1;
			res = '0;
			if (!miss) begin
				res.hit     = 1'b1;
				res.t_enter = t0[COORD_WIDTH-1:0];
				res.t_exit  = t1[COORD_WIDTH-1:0];
			end
			return res;
		endfunction

		function void note_request(rbsi_req_t r);
			expected_hits.push_back(intersect_ray_box(r));
		endfunction

		function void check_response(rbsi_rsp_t got);
			rbsi_rsp_t want;
			responses++;
			if (expected_hits.size() == 0) begin
				$display("%0t: unexpected response hit %0b t_enter %0d t_exit %0d",
					$time, got.hit, got.t_enter, got.t_exit);
				errors++;
				return;
			end
			want = expected_hits.pop_front();
			if (got.hit !== want.hit) begin
				$display("%0t: hit expected %0b actual %0b", $time, want.hit, got.hit);
				errors++;
			end
			if (got.t_enter !== want.t_enter) begin
				$display("%0t: t_enter expected %0d actual %0d",
					$time, want.t_enter, got.t_enter);
				errors++;
			end
			if (got.t_exit !== want.t_exit) begin
				$display("%0t: t_exit expected %0d actual %0d",
					$time, want.t_exit, got.t_exit);
				errors++;
			end
		endfunction

		function void report_leftover();
			if (expected_hits.size() != 0) begin
				$display("%0t: %0d responses never arrived, next expected hit %0b t_enter %0d t_exit %0d",
					$time, expected_hits.size(), expected_hits[0].hit,
					expected_hits[0].t_enter, expected_hits[0].t_exit);
				errors += expected_hits.size();
			end
		endfunction
	endclass

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_ready;
	rbsi_req_t req       = '0;
	logic      rsp_valid;
	logic      rsp_ready = 1'b0;
	rbsi_rsp_t rsp;

	ray_hit_scoreboard sb = new();
	int                burst_left = 1;

	ray_box_slab_intersect_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && req_ready)
				sb.note_request(req);
			if (rsp_valid && rsp_ready)
				sb.check_response(rsp);
		end
	end

	function automatic rbsi_req_t make_req(
		coord_t bx0, coord_t by0, coord_t bz0, coord_t bx1, coord_t by1, coord_t bz1,
		coord_t ox, coord_t oy, coord_t oz, coord_t dx, coord_t dy, coord_t dz);
		rbsi_req_t r;
		r.box_min_x = bx0;
		r.box_min_y = by0;
		r.box_min_z = bz0;
		r.box_max_x = bx1;
		r.box_max_y = by1;
		r.box_max_z = bz1;
		r.origin_x  = ox;
		r.origin_y  = oy;
		r.origin_z  = oz;
		r.dir_x     = dx;
		r.dir_y     = dy;
		r.dir_z     = dz;
		return r;
	endfunction

	function automatic int spread(int unsigned reach);
		return int'($urandom_range(0, 2 * reach)) - int'(reach);
	endfunction

	function automatic coord_t edge_coord();
		case ($urandom_range(0, 5))
		0: return T_MIN;
		1: return T_MAX;
		2: return 0;
		3: return 1;
		4: return -1;
		default: return coord_t'($urandom);
		endcase
	endfunction

	function automatic rbsi_req_t random_ray();
		coord_t    lo [3];
		coord_t    hi [3];
		coord_t    org [3];
		coord_t    dir [3];
		coord_t    sw;
		int        k;
		int        mid;
		int        half;
		int        aim;
		int        sh;
		ray_kind_e kind;
		k = $urandom_range(0, 9);
		kind = (k < 6) ? RAY_AIMED : (k < 8) ? RAY_RAW : (k == 8) ? RAY_EDGE : RAY_SHORT;
		sh = $urandom_range(0, 8);
		for (int a = 0; a < 3; a++) begin
			case (kind)
			RAY_AIMED: begin
				// aim at a point inside the box, one common scale on all axes
				mid = spread(1 << 24);
				half = $urandom_range(0, 1 << 22);
				lo[a] = mid - half;
				hi[a] = mid + half;
				org[a] = spread(1 << 25);
				aim = mid + spread(half) - int'(org[a]);
				dir[a] = aim >>> sh;
				if ($urandom_range(0, 5) == 0) begin
					dir[a] = 0;
					org[a] = mid + spread(half);
				end
				if ($urandom_range(0, 15) == 0) begin
					sw = lo[a];
					lo[a] = hi[a];
					hi[a] = sw;
				end
			end
			RAY_RAW: begin
				lo[a] = coord_t'($urandom);
				hi[a] = coord_t'($urandom);
				org[a] = coord_t'($urandom);
				dir[a] = ($urandom_range(0, 7) == 0) ? coord_t'(0) : coord_t'($urandom);
			end
			RAY_EDGE: begin
				lo[a] = edge_coord();
				hi[a] = edge_coord();
				org[a] = edge_coord();
				dir[a] = edge_coord();
			end
			default: begin
				// small steps against wide spans drive the quotients into clamping
				lo[a] = spread(1 << 20);
				hi[a] = spread(1 << 20);
				org[a] = spread(1 << 20);
				dir[a] = spread(256);
			end
			endcase
		end
		return make_req(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2],
			org[0], org[1], org[2], dir[0], dir[1], dir[2]);
	endfunction

	task automatic send_req(rbsi_req_t r);
		int gap;
		@(negedge clk);
		req <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200)
				: $urandom_range(1, 30);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				@(negedge clk);
				req_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
	endtask

	task automatic run_directed();
		send_req(make_req(-Q_ONE, -Q_ONE, -Q_ONE, Q_ONE, Q_ONE, Q_ONE,
			-5 * Q_ONE, 0, 0, Q_ONE, 0, 0));
		// origin inside: entry lies behind the origin
		send_req(make_req(-Q_ONE, -Q_ONE, -Q_ONE, Q_ONE, Q_ONE, Q_ONE,
			0, 0, 0, Q_ONE, Q_ONE, Q_ONE));
		send_req(make_req(-Q_ONE, -Q_ONE, -Q_ONE, Q_ONE, Q_ONE, Q_ONE,
			Q_ONE / 2, -Q_ONE / 2, 0, 0, 0, 0));
		// parallel rays sitting exactly on the bounds count as inside, just past them miss
		send_req(make_req(-Q_ONE, -Q_ONE, -Q_ONE, Q_ONE, Q_ONE, Q_ONE,
			-Q_ONE, Q_ONE, -Q_ONE, 0, 0, 0));
		send_req(make_req(-Q_ONE, -Q_ONE, -Q_ONE, Q_ONE, Q_ONE, Q_ONE,
			Q_ONE, Q_ONE, Q_ONE, 0, 0, 0));
		send_req(make_req(-Q_ONE, -Q_ONE, -Q_ONE, Q_ONE, Q_ONE, Q_ONE,
			Q_ONE + 1, 0, 0, 0, Q_ONE, 0));
		send_req(make_req(-Q_ONE, -Q_ONE, -Q_ONE, Q_ONE, Q_ONE, Q_ONE,
			0, -Q_ONE - 1, 0, Q_ONE, 0, Q_ONE));
		// inverted box: misses when parallel, reorders otherwise
		send_req(make_req(Q_ONE, -Q_ONE, -Q_ONE, -Q_ONE, Q_ONE, Q_ONE,
			0, 0, 0, 0, Q_ONE, 0));
		send_req(make_req(Q_ONE, -Q_ONE, -Q_ONE, -Q_ONE, Q_ONE, Q_ONE,
			-5 * Q_ONE, 0, 0, Q_ONE, 0, 0));
		// intervals on x and y do not overlap
		send_req(make_req(Q_ONE, Q_ONE, -Q_ONE, 2 * Q_ONE, 2 * Q_ONE, Q_ONE,
			0, 0, 0, Q_ONE, -Q_ONE, 0));
		// grazing an edge: entry equals exit
		send_req(make_req(0, 0, 0, Q_ONE, Q_ONE, Q_ONE,
			-Q_ONE, 0, Q_ONE / 2, Q_ONE, Q_ONE, 0));
		send_req(make_req(1000 * Q_ONE, -Q_ONE, -Q_ONE, 1001 * Q_ONE, Q_ONE, Q_ONE,
			0, 0, 0, 1, 0, 0));
		send_req(make_req(-1001 * Q_ONE, -Q_ONE, -Q_ONE, -1000 * Q_ONE, Q_ONE, Q_ONE,
			0, 0, 0, 1, 0, 0));
		send_req(make_req(T_MIN, T_MIN, T_MIN, T_MIN, T_MIN, T_MIN,
			T_MIN, T_MIN, T_MIN, T_MIN, T_MIN, T_MIN));
		send_req(make_req(T_MAX, T_MAX, T_MAX, T_MAX, T_MAX, T_MAX,
			T_MAX, T_MAX, T_MAX, T_MAX, T_MAX, T_MAX));
		send_req(make_req(T_MIN, T_MIN, T_MIN, T_MAX, T_MAX, T_MAX,
			0, 0, 0, T_MIN, T_MAX, -1));
		send_req(make_req(T_MIN, T_MIN, T_MIN, T_MIN, T_MAX, T_MAX,
			T_MAX, 0, 0, 1, 0, 0));
		// thirds truncate toward zero on both signs
		send_req(make_req(-Q_ONE, -Q_ONE, -Q_ONE, Q_ONE, Q_ONE, Q_ONE,
			0, 0, 0, 3 * Q_ONE, -3 * Q_ONE, 7));
		send_req(make_req(T_MIN, T_MAX, T_MIN, T_MAX, T_MIN, T_MAX,
			-1, 1, T_MIN, -1, 1, T_MAX));
	endtask

	initial begin : response_side
		int       span;
		int       holds;
		rx_pace_e pace;
		holds = 0;
		@(posedge arst_n);
		forever begin
			if (holds < 2 && sb.responses >= 150 + holds * 550) begin
				// hold off long enough for the pipeline to back up into req_ready
				@(negedge clk);
				rsp_ready <= 1'b0;
				repeat (300) @(negedge clk);
				holds++;
			end
			pace = rx_pace_e'($urandom_range(0, 3));
			span = $urandom_range(10, 120);
			repeat (span) begin
				@(negedge clk);
				case (pace)
				RX_ALWAYS: rsp_ready <= 1'b1;
				RX_HALF:   rsp_ready <= 1'($urandom_range(0, 1));
				RX_MOSTLY: rsp_ready <= ($urandom_range(0, 9) != 0);
				default:   rsp_ready <= ($urandom_range(0, 9) == 0);
				endcase
			end
		end
	end

	initial begin : request_side
		int n;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		run_directed();
		for (int i = 0; i < RANDOM_RAYS; i++)
			send_req(random_ray());
		@(negedge clk);
		req_valid <= 1'b0;
		n = 0;
		while (sb.expected_hits.size() != 0 && n < 20000) begin
			@(posedge clk);
			n++;
		end
		// catch any stray response past the pipeline depth
		repeat (80) @(posedge clk);
		sb.report_leftover();
		if (sb.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin : watchdog
		#1_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule

@@ sim.f @@
hw/rtl/rbsi_pkg.sv
hw/rtl/rbsi_slab_div.sv
hw/rtl/rbsi_axis_lane.sv
hw/rtl/rbsi_merge.sv
hw/rtl/ray_box_slab_intersect_unit.sv
tb/ray_box_slab_intersect_unit_test.sv
